[rtl/core/cfp_pkg.sv]
// command frame parser package: byte codes, token phases, result type and defaults
// no dependencies; imported by every module of the parser
`timescale 1ns / 1ps
`default_nettype none

package cfp_pkg;

    // character codes
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_COLON  = 8'h3A;

    // sizes fixed by the result format
    localparam int unsigned FRAME_CNT_W = 8;
    localparam int unsigned OPCODE_MAX  = 7;
    localparam int unsigned OPCODE_W    = 8 * OPCODE_MAX;
    localparam int unsigned OPLEN_W     = 3;
    localparam int unsigned ARG_SLOTS   = 4;
    localparam int unsigned ARG_W       = 32;
    localparam int unsigned ACC_W       = ARG_W + 4;

    // saturation bounds
    localparam logic [ARG_W-1:0] MAG_LIMIT = 32'h8000_0000;
    localparam logic [ARG_W-1:0] POS_MAX   = 32'h7FFF_FFFF;

    // parameter defaults
    localparam int unsigned DEF_FRAME_BYTES  = 31;
    localparam int unsigned DEF_OPCODE_CHARS = 7;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_OPCODE,
        PH_SPACE,
        PH_SIGN,
        PH_DIGITS,
        PH_STOPPED,
        PH_ENDED
    } t_phase;

    typedef logic [ARG_SLOTS-1:0][ARG_W-1:0] t_slots;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode_text;
        logic [OPLEN_W-1:0]  opcode_length;
        t_slots              args;
    } t_result;

endpackage

`default_nettype wire

[rtl/core/cfp_number.sv]
// decimal token arithmetic: one digit step with saturation, and the signed
// value of a finished token; depends on cfp_pkg
`timescale 1ns / 1ps
`default_nettype none

module cfp_number (
    input  wire logic [cfp_pkg::ARG_W-1:0] i_acc_mag,
    input  wire logic                      i_acc_sat,
    input  wire logic [3:0]                i_digit,
    input  wire logic                      i_tok_neg,
    input  wire logic [cfp_pkg::ARG_W-1:0] i_tok_mag,
    input  wire logic                      i_tok_sat,
    output logic      [cfp_pkg::ARG_W-1:0] o_acc_mag,
    output logic                           o_acc_sat,
    output logic      [cfp_pkg::ARG_W-1:0] o_fin_value
);
    import cfp_pkg::*;

    logic [ACC_W-1:0] wide_mag;
    logic [ACC_W-1:0] acc_sum;

    // magnitude * 10 + digit as two shifts and two adds
    assign wide_mag = {4'b0000, i_acc_mag};
    assign acc_sum  = (wide_mag << 3) + (wide_mag << 1) + {{(ACC_W-4){1'b0}}, i_digit};

    always_comb begin
        if (acc_sum > {4'b0000, MAG_LIMIT}) begin
            o_acc_mag = MAG_LIMIT;
            o_acc_sat = 1'b1;
        end else begin
            o_acc_mag = acc_sum[ARG_W-1:0];
            o_acc_sat = i_acc_sat;
        end
    end

    always_comb begin
        if (i_tok_neg) begin
            if (i_tok_sat || i_tok_mag >= MAG_LIMIT) begin
                o_fin_value = MAG_LIMIT;
            end else begin
                o_fin_value = ARG_W'(0) - i_tok_mag;
            end
        end else begin
            if (i_tok_sat || i_tok_mag > POS_MAX) begin
                o_fin_value = POS_MAX;
            end else begin
                o_fin_value = i_tok_mag;
            end
        end
    end

endmodule

`default_nettype wire

[rtl/core/cfp_parse.sv]
// frame and token state: processes one byte per step and forms the result
// when a frame closes; depends on cfp_pkg and cfp_number
`timescale 1ns / 1ps
`default_nettype none

module cfp_parse #(
    parameter int unsigned FRAME_BYTES  = cfp_pkg::DEF_FRAME_BYTES,
    parameter int unsigned OPCODE_CHARS = cfp_pkg::DEF_OPCODE_CHARS
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_step,
    input  wire logic [7:0]       i_byte,
    output logic                  o_emit,
    output cfp_pkg::t_result      o_result
);
    import cfp_pkg::*;

    logic                   r_in_frame,     n_in_frame;
    logic [FRAME_CNT_W-1:0] r_frame_count,  n_frame_count;
    logic [OPCODE_W-1:0]    r_opcode_store, n_opcode_store;
    logic [OPLEN_W-1:0]     r_opcode_count, n_opcode_count;
    logic                   r_opcode_taken, n_opcode_taken;
    t_slots                 r_slots,        n_slots;
    t_phase                 r_phase,        n_phase;
    logic                   r_neg,          n_neg;
    logic [ARG_W-1:0]       r_mag,          n_mag;
    logic                   r_sat,          n_sat;

    logic             is_dollar, is_hash, is_colon, is_nul;
    logic             is_space, is_sign, is_digit;
    logic             frame_full, body, char_ok, start_tok, do_clear;
    t_phase           eff_phase;
    logic             eff_neg, eff_sat;
    logic [ARG_W-1:0] eff_mag;
    logic [ARG_W-1:0] acc_mag, fin_value;
    logic             acc_sat;
    logic             can_finish;
    t_slots           fin_slots;

    // byte classes
    assign is_dollar = (i_byte == CH_DOLLAR);
    assign is_hash   = (i_byte == CH_HASH);
    assign is_colon  = (i_byte == CH_COLON);
    assign is_nul    = (i_byte == CH_NUL);
    assign is_space  = i_byte inside {CH_SPACE, [CH_TAB:CH_CR]};
    assign is_sign   = (i_byte == CH_PLUS) || (i_byte == CH_MINUS);
    assign is_digit  = i_byte inside {[CH_ZERO:CH_NINE]};

    assign frame_full = (r_frame_count >= FRAME_CNT_W'(FRAME_BYTES));
    assign body       = i_step && !is_dollar && r_in_frame && !frame_full;
    assign char_ok    = body && !is_hash && (r_phase != PH_ENDED) && !is_nul && !is_colon;
    assign start_tok  = char_ok && (r_phase == PH_IDLE);
    assign do_clear   = i_step && (is_dollar || (r_in_frame && (frame_full || is_hash)));

    // phase and token fields as seen by this byte, after a token start
    always_comb begin
        eff_phase = r_phase;
        eff_neg   = r_neg;
        eff_mag   = r_mag;
        eff_sat   = r_sat;
        if (start_tok) begin
            if (r_opcode_taken) begin
                eff_phase = PH_SPACE;
                eff_neg   = 1'b0;
                eff_mag   = '0;
                eff_sat   = 1'b0;
            end else begin
                eff_phase = PH_OPCODE;
            end
        end
    end

    cfp_number u_number (
        .i_acc_mag   (eff_mag),
        .i_acc_sat   (eff_sat),
        .i_digit     (i_byte[3:0]),
        .i_tok_neg   (r_neg),
        .i_tok_mag   (r_mag),
        .i_tok_sat   (r_sat),
        .o_acc_mag   (acc_mag),
        .o_acc_sat   (acc_sat),
        .o_fin_value (fin_value)
    );

    // finished token goes into the first zero slot
    assign can_finish = r_phase inside {PH_SPACE, PH_SIGN, PH_DIGITS, PH_STOPPED};

    always_comb begin
        logic found;
        found     = 1'b0;
        fin_slots = r_slots;
        if (can_finish) begin
            for (int i = 0; i < ARG_SLOTS; i++) begin
                if (!found && r_slots[i] == '0) begin
                    fin_slots[i] = fin_value;
                    found        = 1'b1;
                end
            end
        end
    end

    // next phase
    always_comb begin
        n_phase = r_phase;
        if (do_clear) begin
            n_phase = PH_IDLE;
        end else if (body && r_phase != PH_ENDED) begin
            if (is_nul) begin
                n_phase = PH_ENDED;
            end else if (is_colon) begin
                n_phase = PH_IDLE;
            end else begin
                case (eff_phase)
                    PH_SPACE: begin
                        if (is_space) begin
                            n_phase = PH_SPACE;
                        end else if (is_sign) begin
                            n_phase = PH_SIGN;
                        end else if (is_digit) begin
                            n_phase = PH_DIGITS;
                        end else begin
                            n_phase = PH_STOPPED;
                        end
                    end
                    PH_SIGN, PH_DIGITS: begin
                        n_phase = is_digit ? PH_DIGITS : PH_STOPPED;
                    end
                    default: n_phase = eff_phase;
                endcase
            end
        end
    end

    // frame, opcode and token data
    always_comb begin
        n_in_frame     = r_in_frame;
        n_frame_count  = r_frame_count;
        n_opcode_store = r_opcode_store;
        n_opcode_count = r_opcode_count;
        n_opcode_taken = r_opcode_taken;
        n_slots        = r_slots;
        n_neg          = r_neg;
        n_mag          = r_mag;
        n_sat          = r_sat;

        if (i_step && is_dollar) begin
            n_in_frame    = 1'b1;
            n_frame_count = FRAME_CNT_W'(1);
        end else if (i_step && r_in_frame && (frame_full || is_hash)) begin
            n_in_frame    = 1'b0;
            n_frame_count = '0;
        end else if (body) begin
            n_frame_count = r_frame_count + FRAME_CNT_W'(1);
            if (r_phase != PH_ENDED) begin
                if (is_nul || is_colon) begin
                    n_slots = fin_slots;
                end else begin
                    if (start_tok && !r_opcode_taken) begin
                        n_opcode_taken = 1'b1;
                    end
                    if (eff_phase == PH_OPCODE) begin
                        if (r_opcode_count < OPLEN_W'(OPCODE_CHARS)) begin
                            for (int i = 0; i < OPCODE_MAX; i++) begin
                                if (r_opcode_count == OPLEN_W'(i)) begin
                                    n_opcode_store[8*i +: 8] = i_byte;
                                end
                            end
                            n_opcode_count = r_opcode_count + OPLEN_W'(1);
                        end
                    end else begin
                        n_neg = eff_neg;
                        n_mag = eff_mag;
                        n_sat = eff_sat;
                        case (eff_phase)
                            PH_SPACE: begin
                                if (is_space) begin
                                    n_neg = eff_neg;
                                end else if (is_sign) begin
                                    n_neg = (i_byte == CH_MINUS);
                                end else if (is_digit) begin
                                    n_mag = acc_mag;
                                    n_sat = acc_sat;
                                end
                            end
                            PH_SIGN, PH_DIGITS: begin
                                if (is_digit) begin
                                    n_mag = acc_mag;
                                    n_sat = acc_sat;
                                end
                            end
                            default: n_neg = eff_neg;
                        endcase
                    end
                end
            end
        end

        if (do_clear) begin
            n_opcode_store = '0;
            n_opcode_count = '0;
            n_opcode_taken = 1'b0;
            n_slots        = '0;
            n_neg          = 1'b0;
            n_mag          = '0;
            n_sat          = 1'b0;
        end
    end

    // result of a closing hash, with the open token folded in
    assign o_emit                 = body && is_hash;
    assign o_result.opcode_text   = r_opcode_store;
    assign o_result.opcode_length = r_opcode_count;
    assign o_result.args          = fin_slots;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame     <= 1'b0;
            r_frame_count  <= '0;
            r_opcode_store <= '0;
            r_opcode_count <= '0;
            r_opcode_taken <= 1'b0;
            r_slots        <= '0;
            r_phase        <= PH_IDLE;
            r_neg          <= 1'b0;
            r_mag          <= '0;
            r_sat          <= 1'b0;
        end else begin
            r_in_frame     <= n_in_frame;
            r_frame_count  <= n_frame_count;
            r_opcode_store <= n_opcode_store;
            r_opcode_count <= n_opcode_count;
            r_opcode_taken <= n_opcode_taken;
            r_slots        <= n_slots;
            r_phase        <= n_phase;
            r_neg          <= n_neg;
            r_mag          <= n_mag;
            r_sat          <= n_sat;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_frame_count <= FRAME_CNT_W'(FRAME_BYTES))
        else $error("frame byte count beyond frame limit");

    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_frame |-> (r_frame_count == '0 && r_phase == PH_IDLE && !r_opcode_taken))
        else $error("parse state left over outside a frame");

    a_opcode_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_opcode_count <= OPLEN_W'(OPCODE_CHARS)) && (r_opcode_count == '0 || r_opcode_taken))
        else $error("opcode length inconsistent");

endmodule

`default_nettype wire

[rtl/core/command_frame_parser.sv]
// command frame parser: reads '$' opcode ':' arg ... '#' frames from a byte stream
// path: an accepted byte is held in the input register, parsed, and its result captured in the output register
// throughput: one byte per cycle; the parse stage advances whenever the output
//   register is empty or being taken, so a stalled result holds back one byte
// reset: i_rst_n synchronous active low, clears frame, token and handshake state
// depends on cfp_pkg and cfp_parse (which uses cfp_number)
`timescale 1ns / 1ps
`default_nettype none

module command_frame_parser #(
    parameter int unsigned FRAME_BYTES  = cfp_pkg::DEF_FRAME_BYTES,
    parameter int unsigned OPCODE_CHARS = cfp_pkg::DEF_OPCODE_CHARS
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // byte input channel
    input  wire logic                         i_rx_valid,
    output logic                              o_rx_stall,
    input  wire logic [7:0]                   i_rx_byte,
    // result channel
    output logic                              o_res_valid,
    input  wire logic                         i_res_stall,
    output logic [cfp_pkg::OPCODE_W-1:0]      o_opcode_text,
    output logic [cfp_pkg::OPLEN_W-1:0]       o_opcode_length,
    output logic signed [cfp_pkg::ARG_W-1:0]  o_arg_first,
    output logic signed [cfp_pkg::ARG_W-1:0]  o_arg_second,
    output logic signed [cfp_pkg::ARG_W-1:0]  o_arg_third,
    output logic signed [cfp_pkg::ARG_W-1:0]  o_arg_fourth
);
    import cfp_pkg::*;

    // input register: holds one accepted byte until the parse stage takes it
    logic       r_in_valid;
    logic [7:0] r_in_byte;

    // output register: one finished result waiting for the consumer
    logic       r_res_valid;
    t_result    r_res;

    logic       advance;
    logic       step;
    logic       emit;
    t_result    result;

    // parse stage may run when the output slot is free after this edge
    assign advance    = !r_res_valid || !i_res_stall;
    assign step       = r_in_valid && advance;
    assign o_rx_stall = r_in_valid && !advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_rx_stall) begin
            r_in_valid <= i_rx_valid;
        end
    end

    // payload register, loaded on each accepted transaction
    always_ff @(posedge i_clk) begin
        if (i_rx_valid && !o_rx_stall) begin
            r_in_byte <= i_rx_byte;
        end
    end

    cfp_parse #(
        .FRAME_BYTES  (FRAME_BYTES),
        .OPCODE_CHARS (OPCODE_CHARS)
    ) u_parse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_byte   (r_in_byte),
        .o_emit   (emit),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (advance) begin
            r_res_valid <= step && emit;
        end
    end

    // result payload only changes when a new result is captured
    always_ff @(posedge i_clk) begin
        if (step && emit) begin
            r_res <= result;
        end
    end

    assign o_res_valid     = r_res_valid;
    assign o_opcode_text   = r_res.opcode_text;
    assign o_opcode_length = r_res.opcode_length;
    assign o_arg_first     = r_res.args[0];
    assign o_arg_second    = r_res.args[1];
    assign o_arg_third     = r_res.args[2];
    assign o_arg_fourth    = r_res.args[3];

    // stall only while a byte is held behind a blocked result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rx_stall |-> (r_in_valid && r_res_valid && i_res_stall))
        else $error("input stalled without a blocked result");

    // only a closing hash can produce a result
    a_emit_on_hash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && r_in_byte != CH_HASH) |=> !o_res_valid)
        else $error("result produced by a byte other than hash");

    // a held byte is not consumed while the result waits
    a_hold_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_res_valid && i_res_stall) |=> (r_in_valid && $stable(r_in_byte)))
        else $error("held byte lost while result stalled");

endmodule

`default_nettype wire
